@@ hdl/erp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Euclidean rhythm pattern package
// Shared types and constants for the rhythm controller and datapath.
// ----------------------------------------------------------------------------
package erp_pkg;

   // Field widths of the transaction payload.
   localparam int STEPS_W = 5;
   localparam int PULSES_W = 5;
   localparam int ROT_W = 8;
   localparam int MASK_W = 16;
   localparam int PULSES_USED_W = 4;
   localparam int ROT_USED_W = 4;

   // Working width that holds any step request and any step limit.
   localparam int WIDE_W = 6;
   // Width used to resize the internal mask onto the output field.
   localparam int MASK_EXT_W = 32;

   // The rotation remainder is found one dividend bit per cycle.
   localparam int DIV_CNT_W = $clog2(ROT_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ROT_W - 1);

   typedef struct packed {
      logic load;
      logic div_step;
      logic fix;
      logic walk_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic walk_last;
   } status_type;

endpackage
`default_nettype wire

@@ hdl/erp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Euclidean rhythm controller
// Sequences load, rotation reduction, accumulator walk and result hand-off.
// ----------------------------------------------------------------------------
module erp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  erp_pkg::status_type  status,
   output erp_pkg::cmd_type     cmd
);
   import erp_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result published over a pending transaction.");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("Published result not presented.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DIV))
      else $error("Accepted transaction did not start the reduction.");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && status.walk_last) |=> (state_ff == ST_DONE))
      else $error("Walk did not finish on its last step.");

endmodule
`default_nettype wire

@@ hdl/erp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Euclidean rhythm datapath
// Clamps the request, reduces the rotation by restoring division and walks
// a Bresenham accumulator over the steps to build the onset mask.
// ----------------------------------------------------------------------------
module erp_datapath #(
   parameter int MAX_STEPS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire        [erp_pkg::STEPS_W-1:0]     req_steps_requested,
   input  wire        [erp_pkg::PULSES_W-1:0]    req_pulses_requested,
   input  wire signed [erp_pkg::ROT_W-1:0]       req_rotation_requested,
   input  erp_pkg::cmd_type                      cmd,
   output erp_pkg::status_type                   status,
   output logic       [erp_pkg::MASK_W-1:0]      rsp_pattern_mask,
   output logic       [erp_pkg::STEPS_W-1:0]     rsp_steps_used,
   output logic       [erp_pkg::PULSES_USED_W-1:0] rsp_pulses_used,
   output logic       [erp_pkg::ROT_USED_W-1:0]  rsp_rotation_used
);
   import erp_pkg::*;

   localparam int CW = $clog2(MAX_STEPS + 1);
   localparam int IW = $clog2(MAX_STEPS);

   logic [WIDE_W-1:0]    steps_wide;
   logic [WIDE_W-1:0]    steps_clamp;
   logic [WIDE_W-1:0]    pulses_wide;
   logic [WIDE_W-1:0]    pulses_clamp;
   logic [ROT_W-1:0]     rot_mag;

   logic [CW-1:0]        n_ff;
   logic [IW-1:0]        k_ff;
   logic                 neg_ff;
   logic [ROT_W-1:0]     mag_ff;
   logic [CW-1:0]        rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [IW-1:0]        rot_ff;
   logic [IW-1:0]        acc_ff;
   logic [IW-1:0]        pos_ff;
   logic [CW-1:0]        idx_ff;
   logic [MAX_STEPS-1:0] mask_ff;

   logic [CW:0]          rem_sh;
   logic [CW:0]          rem_sub;
   logic [CW-1:0]        rem_in;
   logic [CW-1:0]        rot_neg;
   logic [IW-1:0]        rot_in;
   logic [CW:0]          acc_sum;
   logic [CW:0]          acc_sub;
   logic                 onset;
   logic [IW-1:0]        acc_in;
   logic                 pos_wrap;
   logic [IW-1:0]        pos_in;
   logic [MAX_STEPS-1:0] onset_bit;

   logic [MASK_W-1:0]        mask_out_ff;
   logic [STEPS_W-1:0]       steps_out_ff;
   logic [PULSES_USED_W-1:0] pulses_out_ff;
   logic [ROT_USED_W-1:0]    rot_out_ff;
   logic [MASK_EXT_W-1:0]    mask_ext;
   logic [WIDE_W-1:0]        n_ext;
   logic [WIDE_W-1:0]        k_ext;
   logic [WIDE_W-1:0]        rot_ext;

   always_comb begin
      steps_wide = WIDE_W'(req_steps_requested);
      priority if (steps_wide == '0) begin
         steps_clamp = WIDE_W'(1);
      end else if (steps_wide > WIDE_W'(MAX_STEPS)) begin
         steps_clamp = WIDE_W'(MAX_STEPS);
      end else begin
         steps_clamp = steps_wide;
      end
      pulses_wide = WIDE_W'(req_pulses_requested);
      priority if ((pulses_wide >= steps_clamp) || (steps_clamp == WIDE_W'(1))) begin
         pulses_clamp = steps_clamp - WIDE_W'(1);
      end else if (pulses_wide == '0) begin
         pulses_clamp = WIDE_W'(1);
      end else begin
         pulses_clamp = pulses_wide;
      end
      rot_mag = req_rotation_requested[ROT_W-1] ? (~req_rotation_requested + 1'b1)
                                                : req_rotation_requested;
   end

   always_comb begin
      rem_sh = {rem_ff, mag_ff[ROT_W-1]};
      rem_sub = rem_sh - {1'b0, n_ff};
      rem_in = (rem_sh >= {1'b0, n_ff}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      rot_neg = n_ff - rem_ff;
      rot_in = (neg_ff && (rem_ff != '0)) ? rot_neg[IW-1:0] : rem_ff[IW-1:0];

      acc_sum = (CW+1)'(acc_ff) + (CW+1)'(k_ff);
      acc_sub = acc_sum - {1'b0, n_ff};
      onset = (acc_sum >= {1'b0, n_ff});
      acc_in = onset ? acc_sub[IW-1:0] : acc_sum[IW-1:0];
      pos_wrap = (CW'(pos_ff) == (n_ff - CW'(1)));
      pos_in = pos_wrap ? '0 : (pos_ff + IW'(1));
      onset_bit = onset ? (MAX_STEPS'(1) << pos_ff) : '0;
   end

   assign status.div_last = (div_cnt_ff == DIV_LAST);
   assign status.walk_last = (idx_ff == (n_ff - CW'(1)));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= steps_clamp[CW-1:0];
         k_ff <= pulses_clamp[IW-1:0];
         neg_ff <= req_rotation_requested[ROT_W-1];
         mag_ff <= rot_mag;
         rem_ff <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         mag_ff <= {mag_ff[ROT_W-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.fix) begin
         rot_ff <= rot_in;
         pos_ff <= rot_in;
         acc_ff <= '0;
         idx_ff <= '0;
         mask_ff <= '0;
      end
      if (cmd.walk_step) begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         idx_ff <= idx_ff + CW'(1);
         mask_ff <= mask_ff | onset_bit;
      end
   end

   always_comb begin
      mask_ext = MASK_EXT_W'(mask_ff);
      n_ext = WIDE_W'(n_ff);
      k_ext = WIDE_W'(k_ff);
      rot_ext = WIDE_W'(rot_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         mask_out_ff <= mask_ext[MASK_W-1:0];
         steps_out_ff <= n_ext[STEPS_W-1:0];
         pulses_out_ff <= k_ext[PULSES_USED_W-1:0];
         rot_out_ff <= rot_ext[ROT_USED_W-1:0];
      end
   end

   assign rsp_pattern_mask = mask_out_ff;
   assign rsp_steps_used = steps_out_ff;
   assign rsp_pulses_used = pulses_out_ff;
   assign rsp_rotation_used = rot_out_ff;

   a_pulses_below_steps: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load) |-> (CW'(k_ff) < n_ff))
      else $error("Clamped pulse count is not below the step count.");

   a_rot_reduced: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.fix) |-> (CW'(rot_ff) < n_ff))
      else $error("Reduced rotation is not below the step count.");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> ((CW'(pos_ff) < n_ff) && (CW'(acc_ff) < n_ff)))
      else $error("Walk position or accumulator out of range.");

endmodule
`default_nettype wire

@@ hdl/euclidean_rhythm_pattern.sv @@
`default_nettype none
// A new request is taken only in idle, once the previous result has been
// handed off; req_stall is high until then.
// The rotation reduction takes one dividend bit per cycle, and the
// Bresenham walk takes one step per cycle.
// Reset is synchronous and active high; it clears the controller and the
// result valid flag.
// ----------------------------------------------------------------------------
// Euclidean rhythm pattern generator
// Clamps a rhythm request and produces its rotated onset mask.
// ----------------------------------------------------------------------------
module euclidean_rhythm_pattern #(
   parameter int MAX_STEPS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire        [erp_pkg::STEPS_W-1:0]      req_steps_requested,
   input  wire        [erp_pkg::PULSES_W-1:0]     req_pulses_requested,
   input  wire signed [erp_pkg::ROT_W-1:0]        req_rotation_requested,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic       [erp_pkg::MASK_W-1:0]       rsp_pattern_mask,
   output logic       [erp_pkg::STEPS_W-1:0]      rsp_steps_used,
   output logic       [erp_pkg::PULSES_USED_W-1:0] rsp_pulses_used,
   output logic       [erp_pkg::ROT_USED_W-1:0]   rsp_rotation_used
);
   import erp_pkg::*;

   cmd_type    cmd;
   status_type status;

   erp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   erp_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_steps_requested    (req_steps_requested),
      .req_pulses_requested   (req_pulses_requested),
      .req_rotation_requested (req_rotation_requested),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_pattern_mask       (rsp_pattern_mask),
      .rsp_steps_used         (rsp_steps_used),
      .rsp_pulses_used        (rsp_pulses_used),
      .rsp_rotation_used      (rsp_rotation_used)
   );

endmodule
`default_nettype wire
